// ===== src/uflc_pkg.sv =====
// Shared types, widths and operation codes for the union-find engine.
`default_nettype none

package uflc_pkg;

    // Default node table depth
    localparam int NODE_COUNT_DEF = 1024;

    // Field widths fixed by the item formats
    localparam int NODE_W = 10;
    localparam int SIZE_W = 11;
    localparam int OP_W   = 2;

    // Operation codes
    localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
    localparam logic [OP_W-1:0] OP_UNION = 2'd1;
    localparam logic [OP_W-1:0] OP_FIND  = 2'd2;

    // Input request
    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
    } t_in_item;

    // Result request
    typedef struct packed {
        logic [NODE_W-1:0] root_node;
        logic [SIZE_W-1:0] root_size;
        logic              merged;
        logic              in_largest;
        logic [NODE_W-1:0] largest_node;
        logic [SIZE_W-1:0] largest_size;
        logic              bad_node;
    } t_out_item;

    // One node table entry
    typedef struct packed {
        logic              present;
        logic              is_root;
        logic [NODE_W-1:0] link;
    } t_node;

endpackage

`default_nettype wire

// ===== src/uflc_if.sv =====
// Valid/ready channel interfaces for the input and result requests.
`default_nettype none

interface uflc_in_if;
    import uflc_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface uflc_out_if;
    import uflc_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== src/uflc_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
`default_nettype none

module uflc_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== src/union_find_largest_component.sv =====
// Union-find engine with union by size, path compression and a largest-set record.
// Find, repeated add and union walk link paths up to the root and compress them;
// each link depth walked is at most log2(NODE_COUNT) under union by size.
// Throughput: one request at a time; ready again once its result is offered.
// Reset: a clearing pass over every entry wipes the present flags; record resets to zero.
`default_nettype none

module union_find_largest_component #(
    parameter int NODE_COUNT = uflc_pkg::NODE_COUNT_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    uflc_in_if.sink    i_in,
    uflc_out_if.source o_out
);
    import uflc_pkg::*;

    localparam int AW  = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int SW  = $clog2(NODE_COUNT + 1);
    localparam int NDW = $bits(t_node);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_CHK_A, S_CHK_B, S_WALK, S_PACK,
        S_SZ_A, S_SZ_B, S_REFIND, S_RSIZE, S_DONE
    } t_state;

    typedef enum logic [1:0] {RET_UA, RET_UB, RET_RES} t_ret;

    function automatic logic in_range(input logic [NODE_W-1:0] n);
        return (32'(n) < 32'(NODE_COUNT));
    endfunction

    // Registers and next values
    t_state            r_state, n_state;
    t_ret              r_ret, n_ret;
    logic [AW-1:0]     r_clr, n_clr;
    logic [OP_W-1:0]   r_op, n_op;
    logic [NODE_W-1:0] r_a, n_a, r_b, n_b;
    logic [NODE_W-1:0] r_start, n_start, r_cur, n_cur, r_root, n_root;
    logic [NODE_W-1:0] r_ra, n_ra, r_rb, n_rb;
    logic [SW-1:0]     r_sa, n_sa;
    logic [NODE_W-1:0] r_res_root, n_res_root;
    logic [SW-1:0]     r_res_size, n_res_size;
    logic              r_res_valid, n_res_valid;
    logic              r_merged, n_merged, r_bad, n_bad;
    logic [NODE_W-1:0] r_best_root, n_best_root;
    logic [SW-1:0]     r_best_size, n_best_size;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out, n_out;

    // Memory ports
    logic              nd_we;
    logic [AW-1:0]     nd_waddr, nd_raddr;
    t_node             nd_wdata, nd_rd;
    logic [NDW-1:0]    nd_rdata;
    logic              sz_we;
    logic [AW-1:0]     sz_waddr, sz_raddr;
    logic [SW-1:0]     sz_wdata, sz_rd;

    // Find completion
    logic              fin;
    logic [NODE_W-1:0] fin_root;
    logic [SW-1:0]     sum;

    assign nd_rd = nd_rdata;

    uflc_ram #(.WIDTH(NDW), .DEPTH(NODE_COUNT), .ADDR_W(AW)) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (nd_we),
        .i_waddr (nd_waddr),
        .i_wdata (nd_wdata),
        .i_raddr (nd_raddr),
        .o_rdata (nd_rdata)
    );

    uflc_ram #(.WIDTH(SW), .DEPTH(NODE_COUNT), .ADDR_W(AW)) u_size_ram (
        .i_clk   (i_clk),
        .i_we    (sz_we),
        .i_waddr (sz_waddr),
        .i_wdata (sz_wdata),
        .i_raddr (sz_raddr),
        .o_rdata (sz_rd)
    );

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    assign sum = r_sa + sz_rd;

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_ret       = r_ret;
        n_clr       = r_clr;
        n_op        = r_op;
        n_a         = r_a;
        n_b         = r_b;
        n_start     = r_start;
        n_cur       = r_cur;
        n_root      = r_root;
        n_ra        = r_ra;
        n_rb        = r_rb;
        n_sa        = r_sa;
        n_res_root  = r_res_root;
        n_res_size  = r_res_size;
        n_res_valid = r_res_valid;
        n_merged    = r_merged;
        n_bad       = r_bad;
        n_best_root = r_best_root;
        n_best_size = r_best_size;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_out.ready;
        nd_we       = 1'b0;
        nd_waddr    = AW'(r_cur);
        nd_wdata    = '{present: 1'b1, is_root: 1'b0, link: r_root};
        nd_raddr    = AW'(r_cur);
        sz_we       = 1'b0;
        sz_waddr    = AW'(r_a);
        sz_wdata    = SW'(1);
        sz_raddr    = AW'(r_root);
        fin         = 1'b0;
        fin_root    = r_root;

        unique case (r_state)
            S_CLEAR: begin
                nd_we    = 1'b1;
                nd_waddr = r_clr;
                nd_wdata = '0;
                n_clr    = r_clr + AW'(1);
                if (r_clr == AW'(NODE_COUNT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                nd_raddr = AW'(i_in.data.node_a);
                if (i_in.valid) begin
                    n_op        = i_in.data.operation;
                    n_a         = i_in.data.node_a;
                    n_b         = i_in.data.node_b;
                    n_res_root  = '0;
                    n_res_size  = '0;
                    n_res_valid = 1'b0;
                    n_merged    = 1'b0;
                    n_bad       = 1'b0;
                    unique case (i_in.data.operation) inside
                        OP_ADD, OP_FIND: begin
                            if (in_range(i_in.data.node_a)) begin
                                n_state = S_CHK_A;
                            end else begin
                                n_bad   = 1'b1;
                                n_state = S_DONE;
                            end
                        end
                        OP_UNION: begin
                            if (in_range(i_in.data.node_a) && in_range(i_in.data.node_b)) begin
                                n_state = S_CHK_A;
                            end else begin
                                n_bad   = 1'b1;
                                n_state = S_DONE;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_CHK_A: begin
                if (!nd_rd.present) begin
                    if (r_op == OP_ADD) begin
                        // New singleton root
                        nd_we       = 1'b1;
                        nd_waddr    = AW'(r_a);
                        nd_wdata    = '{present: 1'b1, is_root: 1'b1, link: r_a};
                        sz_we       = 1'b1;
                        sz_waddr    = AW'(r_a);
                        sz_wdata    = SW'(1);
                        if (r_best_size == '0) begin
                            n_best_size = SW'(1);
                            n_best_root = r_a;
                        end
                        n_res_root  = r_a;
                        n_res_size  = SW'(1);
                        n_res_valid = 1'b1;
                    end else begin
                        n_bad = 1'b1;
                    end
                    n_state = S_DONE;
                end else if (r_op == OP_UNION) begin
                    nd_raddr = AW'(r_b);
                    n_state  = S_CHK_B;
                end else begin
                    // Present node on add or find: report its root
                    n_start  = r_a;
                    n_cur    = r_a;
                    nd_raddr = AW'(r_a);
                    n_ret    = RET_RES;
                    n_state  = S_WALK;
                end
            end
            S_CHK_B: begin
                if (!nd_rd.present) begin
                    n_bad   = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_start  = r_a;
                    n_cur    = r_a;
                    nd_raddr = AW'(r_a);
                    n_ret    = RET_UA;
                    n_state  = S_WALK;
                end
            end
            S_WALK: begin
                // Follow links up to the root
                if (nd_rd.is_root) begin
                    n_root = r_cur;
                    if (r_start == r_cur) begin
                        fin      = 1'b1;
                        fin_root = r_cur;
                    end else begin
                        n_cur    = r_start;
                        nd_raddr = AW'(r_start);
                        n_state  = S_PACK;
                    end
                end else begin
                    n_cur    = nd_rd.link;
                    nd_raddr = AW'(nd_rd.link);
                end
            end
            S_PACK: begin
                // Relink each path node straight to the root
                nd_we    = 1'b1;
                nd_waddr = AW'(r_cur);
                nd_wdata = '{present: 1'b1, is_root: 1'b0, link: r_root};
                if (nd_rd.link == r_root) begin
                    fin      = 1'b1;
                    fin_root = r_root;
                end else begin
                    n_cur    = nd_rd.link;
                    nd_raddr = AW'(nd_rd.link);
                end
            end
            S_SZ_A: begin
                n_sa     = sz_rd;
                sz_raddr = AW'(r_rb);
                n_state  = S_SZ_B;
            end
            S_SZ_B: begin
                // Smaller set links under the larger; ties keep node_a's root
                nd_we = 1'b1;
                sz_we = 1'b1;
                sz_wdata = sum;
                if (r_sa < sz_rd) begin
                    nd_waddr = AW'(r_ra);
                    nd_wdata = '{present: 1'b1, is_root: 1'b0, link: r_rb};
                    sz_waddr = AW'(r_rb);
                    if (sum > r_best_size) begin
                        n_best_size = sum;
                        n_best_root = r_rb;
                    end
                end else begin
                    nd_waddr = AW'(r_rb);
                    nd_wdata = '{present: 1'b1, is_root: 1'b0, link: r_ra};
                    sz_waddr = AW'(r_ra);
                    if (sum > r_best_size) begin
                        n_best_size = sum;
                        n_best_root = r_ra;
                    end
                end
                n_merged = 1'b1;
                n_state  = S_REFIND;
            end
            S_REFIND: begin
                n_start  = r_a;
                n_cur    = r_a;
                nd_raddr = AW'(r_a);
                n_ret    = RET_RES;
                n_state  = S_WALK;
            end
            S_RSIZE: begin
                n_res_size  = sz_rd;
                n_res_valid = 1'b1;
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out.root_node    = r_res_root;
                    n_out.root_size    = SIZE_W'(r_res_size);
                    n_out.merged       = r_merged;
                    n_out.in_largest   = r_res_valid && (r_best_size != '0)
                                         && (r_res_root == r_best_root);
                    n_out.largest_node = r_best_root;
                    n_out.largest_size = SIZE_W'(r_best_size);
                    n_out.bad_node     = r_bad;
                    n_out_valid        = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Root found: continue with the caller's next step
        if (fin) begin
            unique case (r_ret)
                RET_UA: begin
                    n_ra     = fin_root;
                    n_start  = r_b;
                    n_cur    = r_b;
                    nd_raddr = AW'(r_b);
                    n_ret    = RET_UB;
                    n_state  = S_WALK;
                end
                RET_UB: begin
                    n_rb = fin_root;
                    if (r_ra == fin_root) begin
                        n_start  = r_a;
                        n_cur    = r_a;
                        nd_raddr = AW'(r_a);
                        n_ret    = RET_RES;
                        n_state  = S_WALK;
                    end else begin
                        sz_raddr = AW'(r_ra);
                        n_state  = S_SZ_A;
                    end
                end
                RET_RES: begin
                    n_res_root = fin_root;
                    sz_raddr   = AW'(fin_root);
                    n_state    = S_RSIZE;
                end
                default: begin
                    n_state = S_DONE;
                end
            endcase
        end
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_ret       <= RET_RES;
            r_best_root <= '0;
            r_best_size <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_ret       <= n_ret;
            r_best_root <= n_best_root;
            r_best_size <= n_best_size;
            r_out_valid <= n_out_valid;
        end
        r_op        <= n_op;
        r_a         <= n_a;
        r_b         <= n_b;
        r_start     <= n_start;
        r_cur       <= n_cur;
        r_root      <= n_root;
        r_ra        <= n_ra;
        r_rb        <= n_rb;
        r_sa        <= n_sa;
        r_res_root  <= n_res_root;
        r_res_size  <= n_res_size;
        r_res_valid <= n_res_valid;
        r_merged    <= n_merged;
        r_bad       <= n_bad;
        r_out       <= n_out;
    end

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking testbench for the union-find engine: directed cases, then random op streams.
`timescale 1ns / 100ps

module tb_top;
    import uflc_pkg::*;

    localparam int NODES     = NODE_COUNT_DEF;
    localparam int CLK_HALF  = 5;
    localparam int MAX_WAIT  = 12;
    localparam int TAIL_CYC  = 120;
    localparam int REPORT_MAX = 10;
    // Operation code the block does not define
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n;

    uflc_in_if  in_ch ();
    uflc_out_if out_ch ();

    union_find_largest_component dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Shadow copy of the node table and the largest-set record
    bit                node_present  [NODES];
    bit                node_is_root  [NODES];
    logic [NODE_W-1:0] node_link     [NODES];
    logic [SIZE_W-1:0] node_set_size [NODES];
    logic [NODE_W-1:0] top_root;
    logic [SIZE_W-1:0] top_size;
    logic [NODE_W-1:0] added_nodes[$];

    t_out_item expected_results[$];

    int fail_count;
    int results_seen;
    int n_add, n_union, n_find, n_spare, n_merged, n_bad;
    bit in_burst, out_burst;

    // Wait before the next request or result; long runs of zero wait now and then
    function automatic int draw_wait(inout bit burst);
        if ($urandom_range(0, 39) == 0)
            burst = !burst;
        if (burst || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, MAX_WAIT);
    endfunction

    // Root of a present node; every node on the walked path is relinked to it
    function automatic logic [NODE_W-1:0] compress_to_root(input logic [NODE_W-1:0] n);
        logic [NODE_W-1:0] r;
        logic [NODE_W-1:0] nxt;
        int                guard;
        r = n;
        guard = 0;
        while (guard < NODES && !node_is_root[r]) begin
            r = node_link[r];
            guard++;
        end
        guard = 0;
        while (guard < NODES && n != r && !node_is_root[n]) begin
            nxt = node_link[n];
            node_link[n] = r;
            n = nxt;
            guard++;
        end
        return r;
    endfunction

    // First set to reach a size keeps the record
    function automatic void record_size(input logic [NODE_W-1:0] root,
                                        input logic [SIZE_W-1:0] size);
        if (size > top_size) begin
            top_size = size;
            top_root = root;
        end
    endfunction

    // Apply one request to the shadow table and return the result it should produce
    function automatic t_out_item predict_result(input t_in_item req);
        t_out_item         res;
        logic [NODE_W-1:0] ra, rb;
        logic [SIZE_W-1:0] sa, sb;
        bit                ok;
        res = '0;
        ok  = 1'b0;
        case (req.operation)
            OP_ADD: begin
                if (!node_present[req.node_a]) begin
                    node_present[req.node_a]  = 1'b1;
                    node_is_root[req.node_a]  = 1'b1;
                    node_link[req.node_a]     = req.node_a;
                    node_set_size[req.node_a] = SIZE_W'(1);
                    added_nodes = {added_nodes, req.node_a};
                    record_size(req.node_a, SIZE_W'(1));
                end
                ok = 1'b1;
            end
            OP_UNION: begin
                if (!node_present[req.node_a] || !node_present[req.node_b]) begin
                    res.bad_node = 1'b1;
                end else begin
                    ra = compress_to_root(req.node_a);
                    rb = compress_to_root(req.node_b);
                    if (ra != rb) begin
                        sa = node_set_size[ra];
                        sb = node_set_size[rb];
                        // smaller set goes under the larger; ties under node_a's root
                        if (sa < sb) begin
                            node_is_root[ra]  = 1'b0;
                            node_link[ra]     = rb;
                            node_set_size[rb] = sa + sb;
                            record_size(rb, sa + sb);
                        end else begin
                            node_is_root[rb]  = 1'b0;
                            node_link[rb]     = ra;
                            node_set_size[ra] = sa + sb;
                            record_size(ra, sa + sb);
                        end
                        res.merged = 1'b1;
                    end
                    ok = 1'b1;
                end
            end
            OP_FIND: begin
                if (!node_present[req.node_a])
                    res.bad_node = 1'b1;
                else
                    ok = 1'b1;
            end
            default: ;
        endcase
        if (ok) begin
            res.root_node  = compress_to_root(req.node_a);
            res.root_size  = node_set_size[res.root_node];
            res.in_largest = (top_size != 0) && (res.root_node == top_root);
        end
        res.largest_node = top_root;
        res.largest_size = top_size;
        return res;
    endfunction

    // Send one request and queue its expected result once it is taken
    task automatic send_request(input logic [OP_W-1:0] op, input logic [NODE_W-1:0] a,
                                input logic [NODE_W-1:0] b);
        t_in_item  req;
        t_out_item res;
        int        gap;
        req.operation = op;
        req.node_a    = a;
        req.node_b    = b;
        gap = draw_wait(in_burst);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= req;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        res = predict_result(req);
        expected_results = {expected_results, res};
        case (op)
            OP_ADD:   n_add++;
            OP_UNION: n_union++;
            OP_FIND:  n_find++;
            default:  n_spare++;
        endcase
        n_merged += res.merged;
        n_bad    += res.bad_node;
    endtask

    // Result side: random stalls on ready, compare each taken result with the oldest expectation
    int        out_stall;
    int        out_gap;
    t_out_item exp_res;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            out_stall    <= 0;
        end else if (out_ch.valid && out_ch.ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_MAX)
                    $display("[%0t] unexpected result %p", $realtime, out_ch.data);
            end else begin
                exp_res = expected_results.pop_front();
                if (out_ch.data.root_node !== exp_res.root_node
                        || out_ch.data.root_size !== exp_res.root_size
                        || out_ch.data.merged !== exp_res.merged
                        || out_ch.data.in_largest !== exp_res.in_largest
                        || out_ch.data.largest_node !== exp_res.largest_node
                        || out_ch.data.largest_size !== exp_res.largest_size
                        || out_ch.data.bad_node !== exp_res.bad_node) begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX) begin
                        $display("[%0t] result %0d mismatch", $realtime, results_seen);
                        $display("    expected %p", exp_res);
                        $display("    actual   %p", out_ch.data);
                    end
                end
            end
            out_gap = draw_wait(out_burst);
            out_stall <= out_gap;
            if (out_gap > 0)
                out_ch.ready <= 1'b0;
        end else if (out_stall > 1) begin
            out_stall <= out_stall - 1;
        end else begin
            out_stall    <= 0;
            out_ch.ready <= 1'b1;
        end
    end

    // Empty table, unused code, duplicate add and the tie rule
    task automatic test_empty_and_tie();
        send_request(OP_FIND, 10'd0, 10'd0);
        send_request(OP_UNION, 10'd0, 10'd1023);
        send_request(OP_SPARE, 10'd1023, 10'd1023);
        send_request(OP_ADD, 10'd0, 10'd1023);
        send_request(OP_ADD, 10'd1023, 10'd0);
        send_request(OP_ADD, 10'd0, 10'd0);
        send_request(OP_UNION, 10'd0, 10'd1023);
        send_request(OP_FIND, 10'd1023, 10'd0);
        send_request(OP_UNION, 10'd1023, 10'd0);
    endtask

    // Absent partner, record holder on equal sizes, smaller-under-larger, path compression
    task automatic test_union_rules();
        send_request(OP_UNION, 10'd0, 10'd512);
        send_request(OP_ADD, 10'd512, 10'd0);
        send_request(OP_ADD, 10'd513, 10'd0);
        send_request(OP_ADD, 10'd514, 10'd0);
        send_request(OP_UNION, 10'd513, 10'd514);
        send_request(OP_UNION, 10'd512, 10'd513);
        send_request(OP_UNION, 10'd0, 10'd512);
        send_request(OP_FIND, 10'd1023, 10'd0);
        send_request(OP_ADD, 10'h155, 10'h2AA);
        send_request(OP_ADD, 10'h2AA, 10'h155);
        send_request(OP_UNION, 10'h155, 10'h2AA);
        send_request(OP_SPARE, 10'h2AA, 10'h155);
        send_request(OP_FIND, 10'h155, 10'h2AA);
        send_request(OP_FIND, 10'd1, 10'd1023);
    endtask

    function automatic logic [NODE_W-1:0] pick_node(input int pct_live);
        if (added_nodes.size() > 0 && $urandom_range(0, 99) < pct_live)
            return added_nodes[$urandom_range(0, added_nodes.size() - 1)];
        return NODE_W'($urandom_range(0, NODES - 1));
    endfunction

    // Random stream, mostly on nodes already in the table so unions build deep trees
    task automatic test_random_ops(input int count);
        int sel;
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < 25)
                send_request(OP_ADD, pick_node(20), pick_node(0));
            else if (sel < 70)
                send_request(OP_UNION, pick_node(95), pick_node(95));
            else if (sel < 93)
                send_request(OP_FIND, pick_node(90), pick_node(0));
            else
                send_request(OP_SPARE, pick_node(50), pick_node(50));
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        top_root     = '0;
        top_size     = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_and_tie();
        test_union_rules();
        test_random_ops(1330);
        in_ch.valid <= 1'b0;

        // drain, then a short tail so a stray extra result is still caught
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYC) @(posedge i_clk);
        fail_count += expected_results.size();

        $display("covered %0d adds, %0d unions (%0d merging), %0d finds, %0d spare codes, %0d bad",
                 n_add, n_union, n_merged, n_find, n_spare, n_bad);
        $display("largest set grew to %0d nodes; %0d results checked, %0d failures",
                 top_size, results_seen, fail_count);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog
    initial begin
        #8ms;
        $display("timeout with %0d results outstanding", expected_results.size());
        $display("status: fail");
        $finish;
    end

endmodule
